FILE: sv/tkls_pkg.sv
// Package for the top-k largest selector.
// Shared constants, mode codes and the result struct. No dependencies.
`default_nettype none
package tkls_pkg;

    localparam int K_MAX_DEF       = 16;
    localparam int WEIGHT_BITS_DEF = 32;
    localparam int ID_BITS         = 32;
    localparam int OUT_W_BITS      = 32;
    localparam int FILL_BITS       = 5;
    localparam int KEEP_BITS       = 5;
    localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_OFFER = 2'd0,
        MODE_DRAIN = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                  valid;
        logic [ID_BITS-1:0]    id;
        logic [OUT_W_BITS-1:0] weight;
        logic                  accepted;
        logic                  evicted;
        logic [FILL_BITS-1:0]  fill;
        logic                  last;
        logic                  no_entry;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/top_k_largest_selector_unit.sv
// Top-k largest selector: configuration register, store RAM, sequencer
// and output register. Depends on tkls_pkg, tkls_ram, tkls_ctrl.
//
// Usage: items arrive on the slave stream (tuser = mode, tdata = id and
// weight). Offer (mode 0) gives one result beat: accepted/evicted flags and,
// on eviction, the displaced entry. Drain (mode 1) gives one beat per held
// entry, heaviest first, tlast on the final one, or a single no-entry beat
// when empty. Clear (mode 2) and mode 3 give no beat.
// One item is worked at a time; o_s_tready is high only when idle.
// An offer into an empty store is written at once; otherwise the lightest
// entry is read and compared, lighter entries are moved back one slot at a
// time over the single RAM read/write port pair, and the new entry is
// written last. A full store rejects an offer that is not heavier.
// Drain reads the held entries in order; clear only empties the store.
// Results pass through an output register; a stalled receiver holds the
// beat, and the sequencer waits at its next result beat until it is taken.
// Reset (synchronous, active low) empties the store and sets keep_count
// to 16; RAM contents are left as they are and never read unwritten.
// Write keep_count only while idle, after a clear.
`default_nettype none
module top_k_largest_selector_unit #(
    parameter int K_MAX       = tkls_pkg::K_MAX_DEF,
    parameter int WEIGHT_BITS = tkls_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,    // keep_count
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,      // entry_id, entry_weight
    input  wire logic [1:0]  i_s_tuser,      // mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,      // out_id, out_weight, fill_level, pad
    output logic [2:0]       o_m_tuser,      // accepted, evicted, no_entry
    output logic             o_m_tlast       // is_last
);
    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(K_MAX+1);
    localparam int DW = tkls_pkg::ID_BITS + WEIGHT_BITS;

    logic [tkls_pkg::KEEP_BITS-1:0] r_keep;
    logic [CW-1:0]                  k_eff;
    logic                           out_free;
    tkls_pkg::t_result              res;
    tkls_pkg::t_result              r_out;
    logic                           re, we;
    logic [AW-1:0]                  ra, wa;
    logic [DW-1:0]                  wd, rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= tkls_pkg::KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_keep == '0) begin
            k_eff = CW'(1);
        end else if (int'(r_keep) > K_MAX) begin
            k_eff = CW'(K_MAX);
        end else begin
            k_eff = CW'(r_keep);
        end
    end

    assign out_free = !r_out.valid || i_m_tready;

    tkls_ram #(.WIDTH(DW), .DEPTH(K_MAX)) u_ram (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_re  (re),
        .i_ra  (ra),
        .o_rd  (rd)
    );

    tkls_ctrl #(.K_MAX(K_MAX), .WEIGHT_BITS(WEIGHT_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_id       (i_s_tdata[31:0]),
        .i_w        (WEIGHT_BITS'(i_s_tdata[63:32])),
        .i_k        (k_eff),
        .i_out_free (out_free),
        .o_res      (res),
        .o_re       (re),
        .o_ra       (ra),
        .o_we       (we),
        .o_wa       (wa),
        .o_wd       (wd),
        .i_rd       (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (out_free) begin
            r_out.valid <= res.valid;
        end
        if (out_free && res.valid) begin
            r_out.id       <= res.id;
            r_out.weight   <= res.weight;
            r_out.accepted <= res.accepted;
            r_out.evicted  <= res.evicted;
            r_out.fill     <= res.fill;
            r_out.last     <= res.last;
            r_out.no_entry <= res.no_entry;
        end
    end

    assign o_m_tvalid = r_out.valid;
    assign o_m_tdata  = {3'b000, r_out.fill, r_out.weight, r_out.id};
    assign o_m_tuser  = {r_out.no_entry, r_out.evicted, r_out.accepted};
    assign o_m_tlast  = r_out.last;
endmodule
`default_nettype wire

FILE: sv/tkls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tkls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [AW-1:0]                    i_wa,
    input  wire logic [WIDTH-1:0]                 i_wd,
    input  wire logic                             i_re,
    input  wire logic [AW-1:0]                    i_ra,
    output logic      [WIDTH-1:0]                 o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;
endmodule
`default_nettype wire

FILE: sv/tkls_ctrl.sv
// Sequencer for the sorted store: offer insertion by read-shift-write,
// drain read-out and clear. Depends on tkls_pkg; drives tkls_ram ports.
`default_nettype none
module tkls_ctrl #(
    parameter int K_MAX       = tkls_pkg::K_MAX_DEF,
    parameter int WEIGHT_BITS = tkls_pkg::WEIGHT_BITS_DEF,
    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1,
    localparam int CW = $clog2(K_MAX+1),
    localparam int DW = tkls_pkg::ID_BITS + WEIGHT_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_mode,
    input  wire logic [tkls_pkg::ID_BITS-1:0] i_id,
    input  wire logic [WEIGHT_BITS-1:0]       i_w,
    input  wire logic [CW-1:0]                i_k,
    input  wire logic                         i_out_free,
    output tkls_pkg::t_result                 o_res,
    output logic                              o_re,
    output logic [AW-1:0]                     o_ra,
    output logic                              o_we,
    output logic [AW-1:0]                     o_wa,
    output logic [DW-1:0]                     o_wd,
    input  wire logic [DW-1:0]                i_rd
);
    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_SHIFT, S_PUT, S_DRN, S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_held, n_held;
    logic [AW-1:0]                   r_dst, n_dst;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [tkls_pkg::ID_BITS-1:0]    r_id, n_id;
    logic [WEIGHT_BITS-1:0]          r_w, n_w;
    logic [tkls_pkg::ID_BITS-1:0]    r_eid, n_eid;
    logic [WEIGHT_BITS-1:0]          r_ew, n_ew;
    logic                            r_acc, n_acc;
    logic                            r_ev, n_ev;
    logic                            r_none, n_none;
    logic                            r_grow, n_grow;

    logic [tkls_pkg::ID_BITS-1:0]    rd_id;
    logic [WEIGHT_BITS-1:0]          rd_w;
    logic [AW-1:0]                   cur_dst;
    logic                            accept;
    logic                            drn_last;

    assign rd_id      = i_rd[tkls_pkg::ID_BITS-1:0];
    assign rd_w       = i_rd[DW-1:tkls_pkg::ID_BITS];
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign cur_dst    = (r_state == S_FIRST) ? AW'(r_held) : r_dst;
    assign drn_last   = (CW'(r_idx) == r_held - CW'(1));

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_dst   = r_dst;
        n_idx   = r_idx;
        n_id    = r_id;
        n_w     = r_w;
        n_eid   = r_eid;
        n_ew    = r_ew;
        n_acc   = r_acc;
        n_ev    = r_ev;
        n_none  = r_none;
        n_grow  = r_grow;
        o_re    = 1'b0;
        o_ra    = '0;
        o_we    = 1'b0;
        o_wa    = '0;
        o_wd    = i_rd;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id   = i_id;
                    n_w    = i_w;
                    n_eid  = '0;
                    n_ew   = '0;
                    n_acc  = 1'b0;
                    n_ev   = 1'b0;
                    n_none = 1'b0;
                    n_grow = 1'b0;
                    case (tkls_pkg::t_mode'(i_mode))
                        tkls_pkg::MODE_OFFER: begin
                            if (r_held == '0) begin
                                o_we    = 1'b1;
                                o_wa    = '0;
                                o_wd    = {i_w, i_id};
                                n_held  = CW'(1);
                                n_acc   = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                o_re    = 1'b1;
                                o_ra    = AW'(r_held - CW'(1));
                                n_state = S_FIRST;
                            end
                        end
                        tkls_pkg::MODE_DRAIN: begin
                            if (r_held == '0) begin
                                n_none  = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                o_re    = 1'b1;
                                o_ra    = '0;
                                n_idx   = '0;
                                n_state = S_DRN;
                            end
                        end
                        tkls_pkg::MODE_CLEAR: n_held = '0;
                        default: ;
                    endcase
                end
            end
            S_FIRST, S_SHIFT: begin
                if (r_state == S_FIRST && r_held >= i_k) begin
                    // store full: contend with the lightest, latest entry
                    if (r_w > rd_w) begin
                        n_acc = 1'b1;
                        n_ev  = 1'b1;
                        n_eid = rd_id;
                        n_ew  = rd_w;
                        n_dst = AW'(r_held - CW'(1));
                        if (r_held == CW'(1)) begin
                            n_state = S_PUT;
                        end else begin
                            o_re    = 1'b1;
                            o_ra    = AW'(r_held - CW'(2));
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    if (r_state == S_FIRST) begin
                        n_acc  = 1'b1;
                        n_grow = 1'b1;
                    end
                    if (rd_w >= r_w) begin
                        n_dst   = cur_dst;
                        n_state = S_PUT;
                    end else begin
                        // move the lighter entry one slot back; read ahead
                        o_we  = 1'b1;
                        o_wa  = cur_dst;
                        o_wd  = i_rd;
                        n_dst = cur_dst - AW'(1);
                        if (cur_dst == AW'(1)) begin
                            n_state = S_PUT;
                        end else begin
                            o_re    = 1'b1;
                            o_ra    = cur_dst - AW'(2);
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_PUT: begin
                o_we = 1'b1;
                o_wa = r_dst;
                o_wd = {r_w, r_id};
                if (r_grow) begin
                    n_held = r_held + CW'(1);
                end
                n_state = S_EMIT;
            end
            S_DRN: begin
                o_re = 1'b1;
                if (i_out_free) begin
                    if (drn_last) begin
                        o_re    = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_ra  = r_idx + AW'(1);
                        n_idx = r_idx + AW'(1);
                    end
                end else begin
                    o_ra = r_idx;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res          = '0;
        o_res.fill     = tkls_pkg::FILL_BITS'(r_held);
        o_res.last     = 1'b1;
        if (r_state == S_DRN) begin
            o_res.valid  = 1'b1;
            o_res.id     = rd_id;
            o_res.weight = tkls_pkg::OUT_W_BITS'(rd_w);
            o_res.last   = drn_last;
        end else if (r_state == S_EMIT) begin
            o_res.valid    = 1'b1;
            o_res.id       = r_eid;
            o_res.weight   = tkls_pkg::OUT_W_BITS'(r_ew);
            o_res.accepted = r_acc;
            o_res.evicted  = r_ev;
            o_res.no_entry = r_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
        end
        r_dst  <= n_dst;
        r_idx  <= n_idx;
        r_id   <= n_id;
        r_w    <= n_w;
        r_eid  <= n_eid;
        r_ew   <= n_ew;
        r_acc  <= n_acc;
        r_ev   <= n_ev;
        r_none <= n_none;
        r_grow <= n_grow;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_held) <= K_MAX)
        else $error("held count above store depth");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re && o_wa == o_ra))
        else $error("read and write of one entry in one cycle");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.no_entry |-> o_res.last && r_held == '0)
        else $error("empty drain result malformed");
    a_evict_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.evicted |-> o_res.accepted && r_state == S_EMIT)
        else $error("eviction without acceptance");
`endif
endmodule
`default_nettype wire

FILE: bench/tkls_checker.sv
// Scoreboard for the top-k largest selector: watches both streams and the
// keep_count write port, predicts every result beat and compares it.
// Depends on tkls_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tkls_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [71:0] i_m_tdata,
    input  wire logic [2:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beats_seen
);
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] weight;
        logic        accepted;
        logic        evicted;
        logic [4:0]  fill;
        logic        last;
        logic        no_entry;
    } t_beat;

    logic [31:0] chain_id [16];
    logic [31:0] chain_wt [16];
    int          n_held;
    int          keep_k;
    t_beat       expected_beats[$];

    assign o_pending = expected_beats.size();

    function automatic t_beat mk(logic [31:0] id, logic [31:0] w, logic acc,
                                 logic ev, logic lst, logic none);
        t_beat b;
        b = '{id, w, acc, ev, n_held[4:0], lst, none};
        return b;
    endfunction

    task automatic queue_beat(t_beat b);
        expected_beats = {expected_beats, b};
    endtask

    // sorted insert behind every entry of equal or greater weight
    task automatic chain_insert(logic [31:0] id, logic [31:0] w);
        int pos;
        pos = 0;
        while (pos < n_held && chain_wt[pos] >= w) pos++;
        for (int i = n_held; i > pos; i--) begin
            chain_id[i] = chain_id[i-1];
            chain_wt[i] = chain_wt[i-1];
        end
        chain_id[pos] = id;
        chain_wt[pos] = w;
        n_held++;
    endtask

    task automatic predict_item(tkls_pkg::t_mode mode, logic [31:0] id, logic [31:0] w);
        int k;
        logic [31:0] eid, ew;
        k = keep_k < 1 ? 1 : (keep_k > 16 ? 16 : keep_k);
        case (mode)
            tkls_pkg::MODE_OFFER: begin
                if (n_held < k) begin
                    chain_insert(id, w);
                    queue_beat(mk('0, '0, 1'b1, 1'b0, 1'b1, 1'b0));
                end else if (w > chain_wt[n_held-1]) begin
                    eid = chain_id[n_held-1];
                    ew  = chain_wt[n_held-1];
                    n_held--;
                    chain_insert(id, w);
                    queue_beat(mk(eid, ew, 1'b1, 1'b1, 1'b1, 1'b0));
                end else begin
                    queue_beat(mk('0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
                end
            end
            tkls_pkg::MODE_DRAIN: begin
                if (n_held == 0)
                    queue_beat(mk('0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
                for (int i = 0; i < n_held; i++)
                    queue_beat(mk(chain_id[i], chain_wt[i], 1'b0, 1'b0,
                                  i == n_held - 1, 1'b0));
            end
            tkls_pkg::MODE_CLEAR: n_held = 0;
            default: ;
        endcase
    endtask

    task automatic cmp(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_beat exp_b;
        if (!i_rst_n) begin
            n_held = 0;
            keep_k = 16;
            expected_beats.delete();
            o_fail_count = 0;
            o_beats_seen = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_beats_seen++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    exp_b = expected_beats.pop_front();
                    cmp("out_id", exp_b.id, i_m_tdata[31:0]);
                    cmp("out_weight", exp_b.weight, i_m_tdata[63:32]);
                    cmp("fill_level", exp_b.fill, i_m_tdata[68:64]);
                    cmp("accepted", exp_b.accepted, i_m_tuser[0]);
                    cmp("evicted", exp_b.evicted, i_m_tuser[1]);
                    cmp("no_entry", exp_b.no_entry, i_m_tuser[2]);
                    cmp("is_last", exp_b.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(tkls_pkg::t_mode'(i_s_tuser), i_s_tdata[31:0],
                             i_s_tdata[63:32]);
            if (i_cfg_we) keep_k = int'(i_cfg_wdata);
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench top for top_k_largest_selector_unit: clock, reset, stimulus,
// keep_count phases, watchdog and verdict. Depends on tkls_pkg, tkls_checker and the unit.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [4:0]  cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count, pending, beats_seen;
    int          idle_cycles = 0;
    int          items_sent = 0;
    bit          hold_sink = 0;
    bit          quiet = 0;

    localparam int WATCHDOG = 20000;

    always #10 clk = ~clk;

    top_k_largest_selector_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    tkls_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_beats_seen(beats_seen)
    );

    // watchdog on cycles with no beat on either stream
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls per beat, or a long hold on request
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (120) @(negedge clk);
                hold_sink = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // tvalid stays up between back-to-back beats; dropped on a gap
    task automatic send(tkls_pkg::t_mode mode, logic [31:0] id, logic [31:0] w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {w, id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_keep(logic [4:0] k);
        wait_idle();
        send(tkls_pkg::MODE_CLEAR, '0, '0);
        wait_idle();
        cfg_we <= 1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // weights drawn half the time from two narrow ranges so that ties are frequent
    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7));
            1: return 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [4:0] keeps [6];
        int r;
        keeps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8};
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: empty drain, extremes, ties, mode 3, overfill at k = 16
        send(tkls_pkg::MODE_DRAIN, '0, '0);
        send(tkls_pkg::MODE_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(tkls_pkg::MODE_OFFER, 32'h0, 32'h0);
        send(tkls_pkg::MODE_OFFER, 32'h1, 32'h0);
        send(tkls_pkg::MODE_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        for (int i = 0; i < 14; i++)
            send(tkls_pkg::MODE_OFFER, 32'(100 + i), 32'h0001_0000);
        send(tkls_pkg::MODE_OFFER, 32'h77, 32'h0);          // tie with lightest: rejected
        send(tkls_pkg::MODE_OFFER, 32'h78, 32'h0000_0001);  // evicts the remaining zero-weight entry
        send(tkls_pkg::MODE_DRAIN, '0, '0);
        send(tkls_pkg::MODE_CLEAR, '0, '0);
        send(tkls_pkg::MODE_DRAIN, '0, '0);

        // lowered k below the number held: nothing dropped
        for (int i = 0; i < 6; i++) send(tkls_pkg::MODE_OFFER, 32'(i), rand_weight());
        wait_idle();
        cfg_we <= 1; cfg_wdata <= 5'd2; @(negedge clk); cfg_we <= 0;
        send(tkls_pkg::MODE_OFFER, 32'h99, $urandom);
        send(tkls_pkg::MODE_DRAIN, '0, '0);

        // receiver held off while offers keep arriving
        hold_sink = 1;
        for (int i = 0; i < 8; i++) send(tkls_pkg::MODE_OFFER, $urandom, $urandom);

        for (int ph = 0; ph < 6; ph++) begin
            set_keep(keeps[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < 33; n++) begin
                r = $urandom_range(0, 99);
                if (r < 78) send(tkls_pkg::MODE_OFFER, $urandom, rand_weight());
                else if (r < 92) send(tkls_pkg::MODE_DRAIN, $urandom, $urandom);
                else if (r < 97) send(tkls_pkg::MODE_CLEAR, $urandom, $urandom);
                else send(tkls_pkg::MODE_NONE, $urandom, $urandom);
            end
            send(tkls_pkg::MODE_DRAIN, '0, '0);
        end
        quiet = 0;

        wait_idle();
        $display("tb: %0d items sent, %0d result beats checked", items_sent, beats_seen);
        $display("tb: covered six keep_count settings, ties, stalls and empty drains");
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
sv/tkls_pkg.sv
sv/tkls_ram.sv
sv/tkls_ctrl.sv
sv/top_k_largest_selector_unit.sv
bench/tkls_checker.sv
bench/tb.sv
